FILE: rtl/arp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arp_pkg
// Shared types and constants of the ARM ELF relocation patch pipeline.
// ----------------------------------------------------------------------------
package arp_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned KIND_W    = 4;
    localparam int unsigned CFG_IDX_W = 2;

    // Relocation kinds; every other code is unknown.
    localparam logic [KIND_W-1:0] KIND_NONE     = 4'd0;
    localparam logic [KIND_W-1:0] KIND_ABS32    = 4'd1;
    localparam logic [KIND_W-1:0] KIND_BRANCH24 = 4'd2;
    localparam logic [KIND_W-1:0] KIND_REL32    = 4'd3;
    localparam logic [KIND_W-1:0] KIND_V4BX     = 4'd4;
    localparam logic [KIND_W-1:0] KIND_STORE    = 4'd5;
    localparam logic [KIND_W-1:0] KIND_RELATIVE = 4'd6;
    localparam logic [KIND_W-1:0] KIND_THUMB    = 4'd7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_BASE = 2'd1;

    localparam logic [WORD_W-1:0] V4BX_KEEP = 32'hf000000f;
    localparam logic [WORD_W-1:0] V4BX_SET  = 32'h01a0f000;
    localparam logic [WORD_W-1:0] THUMB_LOW = 32'h00ffffff;
    localparam logic [WORD_W-1:0] THUMB_SPAN = 32'h01ffffff;

    typedef struct packed {
        logic [KIND_W-1:0] req_type;
        logic [WORD_W-1:0] place_offset;
        logic [WORD_W-1:0] place_word;
        logic [WORD_W-1:0] sym_value;
    } arp_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] new_word;
        logic              reloc_error;
    } arp_out_t;

    // After stage 1: patch address and the kind-specific second operand.
    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] sym;
        logic [WORD_W-1:0] place;
        logic [WORD_W-1:0] opb;
    } arp_s1_t;

    // After stage 2: both operands of the final add.
    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] opa;
        logic [WORD_W-1:0] opb;
    } arp_s2_t;

    // After stage 3: the sum that the packing stage works from.
    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] sum;
    } arp_s3_t;

endpackage : arp_pkg
`default_nettype wire

FILE: rtl/arp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arp_front
// Stage 1: forms the patch address and decodes the addend of the word.
// ----------------------------------------------------------------------------
module arp_front
    import arp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire arp_in_t           cmd,
    input  wire logic [WORD_W-1:0] load_base,
    input  wire logic [WORD_W-1:0] link_base,
    output arp_s1_t                st
);

    logic              valid_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] sym_reg;
    logic [WORD_W-1:0] place_reg;
    logic [WORD_W-1:0] opb_reg;

    logic [WORD_W-1:0] place_next;
    logic [WORD_W-1:0] opb_next;
    logic [15:0]       hi;
    logic [15:0]       lo;
    logic              sg;

    always_comb
    begin
        hi         = cmd.place_word[15:0];
        lo         = cmd.place_word[31:16];
        sg         = hi[10];
        place_next = load_base + cmd.place_offset - link_base;
        case (cmd.req_type)
            KIND_BRANCH24:
            begin
                // Sign-extended 24-bit field, scaled to bytes.
                opb_next = {{6{cmd.place_word[23]}}, cmd.place_word[23:0], 2'b00};
            end
            KIND_THUMB:
            begin
                // J1/J2 decode of the 25-bit offset, then sign extension.
                opb_next = {{7{sg}}, sg, ~(lo[13] ^ sg), ~(lo[11] ^ sg),
                            hi[9:0], lo[10:0], 1'b0};
            end
            KIND_ABS32, KIND_REL32, KIND_RELATIVE:
            begin
                opb_next = cmd.place_word;
            end
            default:
            begin
                opb_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= cmd.req_type;
        word_reg  <= cmd.place_word;
        sym_reg   <= cmd.sym_value;
        place_reg <= place_next;
        opb_reg   <= opb_next;
    end

    assign st = '{valid: valid_reg, kind: kind_reg, word: word_reg, sym: sym_reg,
                  place: place_reg, opb: opb_reg};

endmodule : arp_front
`default_nettype wire

FILE: rtl/arp_adder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arp_adder
// Stages 2 and 3: subtracts the patch address from the symbol (ABS32, STORE
// and RELATIVE take the symbol as is), then adds the kind-specific operand.
// ----------------------------------------------------------------------------
module arp_adder
    import arp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire arp_s1_t st_in,
    output arp_s3_t      st_out
);

    logic              v2_reg;
    logic [KIND_W-1:0] kind2_reg;
    logic [WORD_W-1:0] word2_reg;
    logic [WORD_W-1:0] opa2_reg;
    logic [WORD_W-1:0] opb2_reg;

    logic              v3_reg;
    logic [KIND_W-1:0] kind3_reg;
    logic [WORD_W-1:0] word3_reg;
    logic [WORD_W-1:0] sum3_reg;

    logic [WORD_W-1:0] opa2_next;
    logic [WORD_W-1:0] sum3_next;

    always_comb
    begin
        case (st_in.kind)
            KIND_ABS32, KIND_STORE, KIND_RELATIVE:
            begin
                opa2_next = st_in.sym;
            end
            default:
            begin
                opa2_next = st_in.sym - st_in.place;
            end
        endcase
        sum3_next = opa2_reg + opb2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= st_in.valid;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        kind2_reg <= st_in.kind;
        word2_reg <= st_in.word;
        opa2_reg  <= opa2_next;
        opb2_reg  <= st_in.opb;
        kind3_reg <= kind2_reg;
        word3_reg <= word2_reg;
        sum3_reg  <= sum3_next;
    end

    assign st_out = '{valid: v3_reg, kind: kind3_reg, word: word3_reg, sum: sum3_reg};

endmodule : arp_adder
`default_nettype wire

FILE: rtl/arp_pack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arp_pack
// Stage 4: checks the Thumb offset, re-encodes the fields and registers
// the result.
// ----------------------------------------------------------------------------
module arp_pack
    import arp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire arp_s3_t st_in,
    output logic         done,
    output arp_out_t     result
);

    logic              done_reg;
    logic [WORD_W-1:0] word_reg;
    logic              err_reg;

    logic [WORD_W-1:0] word_next;
    logic              err_next;
    logic [WORD_W-1:0] off;
    logic [WORD_W-1:0] off_bias;
    logic              thumb_ok;
    logic [15:0]       hi;
    logic [15:0]       lo;
    logic [15:0]       nhi;
    logic [15:0]       nlo;
    logic              sg;
    logic              j1;
    logic              j2;

    always_comb
    begin
        off      = st_in.sum;
        hi       = st_in.word[15:0];
        lo       = st_in.word[31:16];
        // The offset must carry the Thumb bit and lie strictly within 16 MiB.
        off_bias = off + THUMB_LOW;
        thumb_ok = off[0] && (off_bias < THUMB_SPAN);
        sg       = off[24];
        j1       = sg ^ ~off[23];
        j2       = sg ^ ~off[22];
        nhi      = {hi[15:11], sg, off[21:12]};
        nlo      = {lo[15:14], j1, lo[12], j2, off[11:1]};

        word_next = st_in.word;
        err_next  = 1'b0;
        case (st_in.kind)
            KIND_NONE:
            begin
                word_next = st_in.word;
            end
            KIND_ABS32, KIND_REL32, KIND_STORE, KIND_RELATIVE:
            begin
                word_next = st_in.sum;
            end
            KIND_BRANCH24:
            begin
                word_next = {st_in.word[31:24], st_in.sum[25:2]};
            end
            KIND_V4BX:
            begin
                word_next = (st_in.word & V4BX_KEEP) | V4BX_SET;
            end
            KIND_THUMB:
            begin
                if (thumb_ok)
                begin
                    word_next = {nlo, nhi};
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
            default:
            begin
                err_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= st_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        err_reg  <= err_next;
    end

    assign done   = done_reg;
    assign result = '{new_word: word_reg, reloc_error: err_reg};

endmodule : arp_pack
`default_nettype wire

FILE: rtl/arm_elf_relocation_patch_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arm_elf_relocation_patch_top
// Applies one ARM ELF32 relocation to one 32-bit word per clock cycle.
// ----------------------------------------------------------------------------
// A relocation transfer is taken at every rising edge with start high and
// busy low; busy is never raised, so one relocation may be issued in every
// cycle. Each relocation runs through four register stages (patch address and
// addend decode, symbol minus place, final add, Thumb check and field packing)
// and its result appears on result for exactly one cycle, marked by done.
// Results leave in issue order. The receiver must take every result in the
// cycle it is shown, since there is no way to hold it off. The load and link
// bases are written through the cfg channel, which is always ready; they
// should only be changed while no relocation is in flight. Writes to an
// index other than the two bases are ignored.
// ----------------------------------------------------------------------------
module arm_elf_relocation_patch_top
    import arp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire arp_in_t              cmd,
    output logic                      done,
    output arp_out_t                  result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data
);

    logic [WORD_W-1:0] load_base_reg;
    logic [WORD_W-1:0] link_base_reg;
    logic              accept;
    arp_s1_t           st1;
    arp_s3_t           st3;

    // The pipeline never stalls, so both channels are always open.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_base_reg <= '0;
            link_base_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LOAD_BASE:
                begin
                    load_base_reg <= cfg_data;
                end
                CFG_LINK_BASE:
                begin
                    link_base_reg <= cfg_data;
                end
                default:
                begin
                    // Unmapped index: the transfer completes and is dropped.
                end
            endcase
        end
    end

    // Stage 1: patch address and addend decode.
    arp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .cmd       (cmd),
        .load_base (load_base_reg),
        .link_base (link_base_reg),
        .st        (st1)
    );

    // Stages 2 and 3: symbol minus place, then the final add.
    arp_adder u_adder (
        .clk    (clk),
        .rst_n  (rst_n),
        .st_in  (st1),
        .st_out (st3)
    );

    // Stage 4: Thumb range check, field packing and the result register.
    arp_pack u_pack (
        .clk    (clk),
        .rst_n  (rst_n),
        .st_in  (st3),
        .done   (done),
        .result (result)
    );

    // Every accepted relocation produces a result strobe on done.
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 done)
        else $error("accepted relocation did not complete after four cycles");

    // No result appears without a matching accepted relocation.
    a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 4))
        else $error("result strobe without a matching start transfer");

    // An unknown kind always flags an error and returns the original word.
    a_unknown_kind : assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd.req_type > KIND_THUMB) |-> ##4
        (result.reloc_error && result.new_word == $past(cmd.place_word, 4)))
        else $error("unknown relocation kind not flagged");

endmodule : arm_elf_relocation_patch_top
`default_nettype wire
